### rtl/core/ps2mct_pkg.sv
// Package: shared types and constants for the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps
package ps2mct_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    localparam int POS_X_W = (SCREEN_WIDTH  > 2) ? $clog2(SCREEN_WIDTH)  : 1;
    localparam int POS_Y_W = (SCREEN_HEIGHT > 2) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int SUM_X_W = POS_X_W + 9;
    localparam int SUM_Y_W = POS_Y_W + 9;

    localparam int DATA_W     = 8;
    localparam int OUT_DATA_W = 136;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_REPORTING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL     = 1'b1;

    localparam int          SYNC_BIT    = 3;
    localparam logic [7:0]  OVF_MASK    = 8'hC0;
    localparam logic [1:0]  POS_FIRST   = 2'd0;
    localparam logic [1:0]  POS_THIRD   = 2'd2;
    localparam logic [1:0]  POS_FOURTH  = 2'd3;

    typedef struct packed {
        logic       done;
        logic [7:0] first;
        logic [7:0] move_x;
        logic [7:0] move_y;
        logic [3:0] wheel;
    } packet_t;

    typedef struct packed {
        logic [31:0]        packet_count;
        logic [31:0]        wheel_events;
        logic [31:0]        wheel_total;
        logic signed [8:0]  delta_y;
        logic signed [7:0]  delta_x;
        logic [2:0]         button_bits;
        logic [7:0]         cursor_y;
        logic [8:0]         cursor_x;
    } result_t;

endpackage

### rtl/core/ps2_mouse_packet_cursor_tracker.sv
// Top level: PS/2 mouse packet decoder with cursor tracking.
//
// Usage:
//   s_tdata carries one raw mouse byte per word. Bytes are gathered into
//   3-byte packets, or 4-byte packets when the wheel register is set; a
//   first byte without its sync bit is dropped, and all bytes are dropped
//   while reporting is disabled. Each completed packet yields one word on
//   m_tdata with cursor, buttons, deltas and running wheel/packet counts.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Flow: an accepted byte waits in the input register, where it is decoded;
//   a byte that finishes a packet then loads its result word and m_tvalid.
// Throughput: one byte per cycle, set by the single decode stage between the
//   input register and the result register, unless a finished packet waits.
// Reset: counters and wheel total clear, cursor goes to mid-screen,
//   registers clear (reporting off, 3-byte packets).
// Stall: when m_tready is low the result word holds; bytes that do not
//   finish a packet keep flowing, and s_tready drops only once the input
//   register holds a byte that finishes another packet, until the word leaves.
`timescale 1ns / 1ps
module ps2_mouse_packet_cursor_tracker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ps2mct_pkg::DATA_W-1:0]       s_tdata,    // data_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cursor_x, cursor_y, button_bits, delta_x, delta_y, wheel_total,
    // wheel_events, packet_count, zero pad
    output logic [ps2mct_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                                cfg_we,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                                cfg_data
);
    import ps2mct_pkg::*;

    logic       reporting_reg;
    logic       wheel_mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    packet_t    packet;
    result_t    result;
    logic       out_free;
    logic       stage_go;
    logic       fire;

    assign out_free = !out_valid_reg || m_tready;
    assign stage_go = !packet.done || out_free;
    assign fire     = in_valid_reg && stage_go;
    assign s_tready = !in_valid_reg || stage_go;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reporting_reg  <= 1'b0;
            wheel_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REPORTING: reporting_reg  <= cfg_data;
                REG_WHEEL:     wheel_mode_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;

            if (fire && packet.done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (fire && packet.done)
            out_data_reg <= result;
    end

    ps2mct_assembler u_assembler
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .data_byte         (in_byte_reg),
        .reporting_enabled (reporting_reg),
        .wheel_packets     (wheel_mode_reg),
        .packet            (packet)
    );

    ps2mct_tracker u_tracker
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .packet (packet),
        .result (result)
    );

endmodule

### rtl/core/ps2mct_assembler.sv
// Packet assembler: sync check, byte gathering and packet completion.
`timescale 1ns / 1ps
module ps2mct_assembler
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic [7:0]              data_byte,
    input  logic                    reporting_enabled,
    input  logic                    wheel_packets,
    output ps2mct_pkg::packet_t     packet
);
    import ps2mct_pkg::*;

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] held_reg [3];
    logic       take;
    logic       complete;

    always_comb
    begin
        take     = reporting_enabled && !(pos_reg == POS_FIRST && !data_byte[SYNC_BIT]);
        complete = wheel_packets ? (pos_reg == POS_FOURTH) : (pos_reg >= POS_THIRD);
        pos_next = pos_reg;
        if (take)
        begin
            pos_next = complete ? POS_FIRST : pos_reg + 2'd1;
        end
    end

    always_comb
    begin
        packet.done   = take && complete;
        packet.first  = held_reg[0];
        packet.move_x = held_reg[1];
        packet.move_y = (pos_reg == POS_THIRD) ? data_byte : held_reg[2];
        packet.wheel  = wheel_packets ? data_byte[3:0] : 4'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && take && !complete)
        begin
            case (pos_reg)
                2'd0:    held_reg[0] <= data_byte;
                2'd1:    held_reg[1] <= data_byte;
                2'd2:    held_reg[2] <= data_byte;
                default: held_reg[0] <= data_byte;
            endcase
        end
    end

endmodule

### rtl/core/ps2mct_tracker.sv
// Tracker: delta decode, cursor clamp and wheel and packet counters.
`timescale 1ns / 1ps
module ps2mct_tracker
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  ps2mct_pkg::packet_t     packet,
    output ps2mct_pkg::result_t     result
);
    import ps2mct_pkg::*;

    localparam logic signed [SUM_X_W-1:0] X_MAX = SUM_X_W'(SCREEN_WIDTH - 1);
    localparam logic signed [SUM_Y_W-1:0] Y_MAX = SUM_Y_W'(SCREEN_HEIGHT - 1);

    logic [POS_X_W-1:0]       pos_x_reg;
    logic [POS_X_W-1:0]       pos_x_next;
    logic [POS_Y_W-1:0]       pos_y_reg;
    logic [POS_Y_W-1:0]       pos_y_next;
    logic [31:0]              wheel_sum_reg;
    logic [31:0]              wheel_sum_next;
    logic [31:0]              wheel_cnt_reg;
    logic [31:0]              wheel_cnt_next;
    logic [31:0]              packet_cnt_reg;
    logic [31:0]              packet_cnt_next;
    logic signed [7:0]        dx;
    logic signed [7:0]        dy;
    logic signed [SUM_X_W-1:0] sum_x;
    logic signed [SUM_Y_W-1:0] sum_y;
    logic                     wheel_hit;

    always_comb
    begin
        if ((packet.first & OVF_MASK) != 8'd0)
        begin
            dx = 8'sd0;
            dy = 8'sd0;
        end
        else
        begin
            dx = signed'(packet.move_x);
            dy = signed'(packet.move_y);
        end

        sum_x = signed'({{9{1'b0}}, pos_x_reg}) + SUM_X_W'(dx);
        sum_y = signed'({{9{1'b0}}, pos_y_reg}) - SUM_Y_W'(dy);

        if (sum_x < 0)
            pos_x_next = '0;
        else if (sum_x > X_MAX)
            pos_x_next = POS_X_W'(SCREEN_WIDTH - 1);
        else
            pos_x_next = sum_x[POS_X_W-1:0];

        if (sum_y < 0)
            pos_y_next = '0;
        else if (sum_y > Y_MAX)
            pos_y_next = POS_Y_W'(SCREEN_HEIGHT - 1);
        else
            pos_y_next = sum_y[POS_Y_W-1:0];

        wheel_hit       = packet.wheel != 4'd0;
        wheel_sum_next  = wheel_hit ? wheel_sum_reg + {{28{packet.wheel[3]}}, packet.wheel}
                                    : wheel_sum_reg;
        wheel_cnt_next  = wheel_hit ? wheel_cnt_reg + 32'd1 : wheel_cnt_reg;
        packet_cnt_next = packet_cnt_reg + 32'd1;
    end

    always_comb
    begin
        result.cursor_x     = 9'(pos_x_next);
        result.cursor_y     = 8'(pos_y_next);
        result.button_bits  = packet.first[2:0];
        result.delta_x      = dx;
        result.delta_y      = -9'(dy);
        result.wheel_total  = wheel_sum_next;
        result.wheel_events = wheel_cnt_next;
        result.packet_count = packet_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= POS_X_W'(SCREEN_WIDTH / 2);
            pos_y_reg      <= POS_Y_W'(SCREEN_HEIGHT / 2);
            wheel_sum_reg  <= '0;
            wheel_cnt_reg  <= '0;
            packet_cnt_reg <= '0;
        end
        else if (fire && packet.done)
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            wheel_sum_reg  <= wheel_sum_next;
            wheel_cnt_reg  <= wheel_cnt_next;
            packet_cnt_reg <= packet_cnt_next;
        end
    end

endmodule

### tb/sv/ps2_mouse_packet_cursor_tracker_tb.sv
// Testbench: PS/2 mouse packet cursor tracker, self-checking against a packet decoder model.
`timescale 1ns / 1ps
module ps2_mouse_packet_cursor_tracker_tb;
    import ps2mct_pkg::*;

    localparam int HALF_PERIOD = 10;

    class cursor_scoreboard;
        bit          reporting;
        bit          wheel_mode;
        int unsigned byte_pos;
        logic [7:0]  held [3];
        int          pos_x;
        int          pos_y;
        logic [31:0] wheel_sum;
        logic [31:0] wheel_hits;
        logic [31:0] packets;
        result_t     pending_reports [$];
        int          errors;
        int          checked;

        function new();
            reporting  = 1'b0;
            wheel_mode = 1'b0;
            byte_pos   = 0;
            foreach (held[i]) held[i] = 8'h00;
            pos_x      = SCREEN_WIDTH / 2;
            pos_y      = SCREEN_HEIGHT / 2;
            wheel_sum  = '0;
            wheel_hits = '0;
            packets    = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
            if (idx == REG_REPORTING)
                reporting = val;
            else if (idx == REG_WHEEL)
                wheel_mode = val;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0]  pk [4];
            int unsigned size;
            int          dx;
            int          dy;
            int          whl;
            result_t     r;
            size = wheel_mode ? 4 : 3;
            whl  = 0;
            if (!reporting)
                return;
            if (byte_pos == POS_FIRST && !b[SYNC_BIT])
                return;
            if (byte_pos + 1 < size)
            begin
                held[byte_pos] = b;
                byte_pos++;
                return;
            end
            for (int i = 0; i < 3; i++)
                pk[i] = held[i];
            pk[3] = 8'h00;
            if (byte_pos < 3)
                pk[byte_pos] = b;
            else
                pk[3] = b;
            byte_pos = 0;
            dx = int'($signed(pk[1]));
            dy = int'($signed(pk[2]));
            if ((pk[0] & OVF_MASK) != 0)
            begin
                dx = 0;
                dy = 0;
            end
            if (size == 4)
                whl = int'($signed(pk[3][3:0]));
            pos_x = pos_x + dx;
            if (pos_x < 0) pos_x = 0;
            if (pos_x > SCREEN_WIDTH - 1) pos_x = SCREEN_WIDTH - 1;
            pos_y = pos_y - dy;
            if (pos_y < 0) pos_y = 0;
            if (pos_y > SCREEN_HEIGHT - 1) pos_y = SCREEN_HEIGHT - 1;
            if (whl != 0)
            begin
                wheel_sum  = wheel_sum + 32'(whl);
                wheel_hits = wheel_hits + 1;
            end
            packets = packets + 1;
            r.cursor_x     = pos_x[8:0];
            r.cursor_y     = pos_y[7:0];
            r.button_bits  = pk[0][2:0];
            r.delta_x      = 8'(dx);
            r.delta_y      = 9'(-dy);
            r.wheel_total  = wheel_sum;
            r.wheel_events = wheel_hits;
            r.packet_count = packets;
            pending_reports.push_back(r);
        endfunction

        task report_mismatch(string field, longint got, longint want);
            if (errors < 50)
                $display("%0t mismatch %s: got %0d, want %0d", $realtime, field, got, want);
            errors++;
        endtask

        task check_report(result_t got);
            result_t want;
            if (pending_reports.size() == 0)
            begin
                report_mismatch("unexpected word, packet_count", got.packet_count, -1);
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            if (got.cursor_x !== want.cursor_x)
                report_mismatch("cursor_x", got.cursor_x, want.cursor_x);
            if (got.cursor_y !== want.cursor_y)
                report_mismatch("cursor_y", got.cursor_y, want.cursor_y);
            if (got.button_bits !== want.button_bits)
                report_mismatch("button_bits", got.button_bits, want.button_bits);
            if (got.delta_x !== want.delta_x)
                report_mismatch("delta_x", got.delta_x, want.delta_x);
            if (got.delta_y !== want.delta_y)
                report_mismatch("delta_y", got.delta_y, want.delta_y);
            if (got.wheel_total !== want.wheel_total)
                report_mismatch("wheel_total", got.wheel_total, want.wheel_total);
            if (got.wheel_events !== want.wheel_events)
                report_mismatch("wheel_events", got.wheel_events, want.wheel_events);
            if (got.packet_count !== want.packet_count)
                report_mismatch("packet_count", got.packet_count, want.packet_count);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;     // data_byte
    logic                  m_tvalid;
    logic                  m_tready;
    // cursor_x, cursor_y, button_bits, delta_x, delta_y, wheel_total,
    // wheel_events, packet_count, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic                  cfg_data;

    bit hold_request;
    bit no_idle;
    int live_bytes;
    int cfg_writes;

    cursor_scoreboard sb = new();

    ps2_mouse_packet_cursor_tracker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_report(result_t'(m_tdata[$bits(result_t)-1:0]));
    end

    // sink side
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (59) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                stall = no_idle ? 0 : pick_gap();
                if (stall == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        if (sb.reporting)
            live_bytes++;
        sb.note_byte(b);
    endtask

    task automatic send_packet(int size, bit ovf);
        logic [7:0] head;
        head = 8'($urandom_range(0, 255));
        head[SYNC_BIT] = 1'b1;
        if (!ovf)
            head[7:6] = 2'b00;
        else if (head[7:6] == 2'b00)
            head[7:6] = 2'($urandom_range(1, 3));
        send_byte(head);
        for (int i = 1; i < size; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // stop offering, then wait for every report plus the pipeline depth
    task automatic drain();
        @(negedge clk) s_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        cfg_writes++;
    endtask

    initial
    begin
        int phase;
        int n;
        int size;
        bit ovf;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reporting off after reset: ignored
        send_byte(8'h08);
        send_byte(8'h80);
        drain();
        write_reg(REG_REPORTING, 1'b1);
        // no sync bit, extremes, overflow, sign bits
        send_byte(8'h00);
        send_byte(8'h0F); send_byte(8'h7F); send_byte(8'h80);
        send_byte(8'hC8); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h18); send_byte(8'h80); send_byte(8'h7F);
        drain();
        write_reg(REG_WHEEL, 1'b1);
        send_byte(8'h09); send_byte(8'h01); send_byte(8'h01); send_byte(8'h07);
        send_byte(8'h0A); send_byte(8'h00); send_byte(8'h00); send_byte(8'hF8);
        // three bytes gathered, then switch to 3-byte packets
        send_byte(8'h0C); send_byte(8'h10); send_byte(8'h10);
        drain();
        write_reg(REG_WHEEL, 1'b0);
        send_byte(8'h0F);
        // partial packet kept across reporting off
        send_byte(8'h08); send_byte(8'h01);
        drain();
        write_reg(REG_REPORTING, 1'b0);
        send_byte(8'hFF);
        drain();
        write_reg(REG_REPORTING, 1'b1);
        send_byte(8'h02);

        phase = 0;
        while (live_bytes < 360)
        begin
            drain();
            write_reg(REG_REPORTING, (phase == 2) ? 1'b1 : ($urandom_range(0, 9) != 0));
            write_reg(REG_WHEEL, 1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 4) == 0);
            if (phase == 2)
            begin
                no_idle = 1'b1;
                hold_request = 1'b1;
            end
            n = $urandom_range(8, 20);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    size = sb.wheel_mode ? 4 : 3;
                    if ($urandom_range(0, 9) == 0)
                        size = $urandom_range(1, 4);
                    ovf = ($urandom_range(0, 7) == 0);
                    send_packet(size, ovf);
                end
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d live bytes over %0d phases and %0d register writes.",
                 live_bytes, phase, cfg_writes);
        $display("Checked %0d packet reports, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
